FILE: rtl/mp2d_pkg.sv
// Shared constants and types of the 2-D max pooling block.
// No dependencies; every other file but mp2d_if.sv imports this package.
`timescale 1ns / 1ps

package mp2d_pkg;

  // Default sizing of the block
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_MAX_KERNEL  = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Widths of the configuration registers
  localparam int KER_REG_W  = 4;
  localparam int STR_REG_W  = 4;
  localparam int PAD_REG_W  = 3;
  localparam int SIZE_REG_W = 11;

  // Width of an effective kernel size (1 up to the largest kernel, MAX_KERNEL)
  localparam int KER_EFF_W = 5;

  // Reset values of the configuration registers
  localparam logic [KER_REG_W-1:0]  KER_RST  = 4'd2;
  localparam logic [STR_REG_W-1:0]  STR_RST  = 4'd2;
  localparam logic [PAD_REG_W-1:0]  PAD_RST  = 3'd0;
  localparam logic [SIZE_REG_W-1:0] SIZE_RST = 11'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_ROWS = 3'd0,
    REG_KERNEL_COLS = 3'd1,
    REG_STRIDE_ROWS = 3'd2,
    REG_STRIDE_COLS = 3'd3,
    REG_PAD_ROWS    = 3'd4,
    REG_PAD_COLS    = 3'd5,
    REG_IN_ROWS     = 3'd6,
    REG_IN_COLS     = 3'd7
  } cfg_reg_t;

  // Effective window geometry of one axis
  typedef struct packed {
    logic [KER_EFF_W-1:0] kernel;
    logic [STR_REG_W-1:0] stride;
    logic [PAD_REG_W-1:0] pad;
  } axis_cfg_t;

endpackage

FILE: rtl/mp2d_if.sv
// Valid/ready stream interfaces of the max pooling block: sample in, result out.
// No dependencies.
`timescale 1ns / 1ps

interface mp2d_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mp2d_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int IDX_BITS    = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pooled;
  logic [IDX_BITS-1:0]    out_row;
  logic [IDX_BITS-1:0]    out_col;
  logic                   end_of_plane;
  logic                   last;

  modport source (output valid, output pooled, output out_row, output out_col,
                  output end_of_plane, output last, input ready);
  modport sink   (input valid, input pooled, input out_row, input out_col,
                  input end_of_plane, input last, output ready);
endinterface

FILE: rtl/max_pool_2d_unit.sv
// Top level of the streaming 2-D max pooling block.
// Depends on mp2d_pkg, mp2d_if, mp2d_axis_trk, mp2d_cell and mp2d_emitter.
//
// Usage:
//   in_ch takes one sample word per cycle, planes in raster order (rows top
//   to bottom, columns left to right). out_ch gives one word per finished
//   window: the maximum, its output row and column, end_of_plane on the
//   plane's final window and last on the final word caused by a sample.
//   cfg_we/cfg_index/cfg_wdata write the geometry registers; a write restarts
//   the plane and holds in_ch.ready low for one cycle. Write only while idle.
// A word's path: the column-maxima stage, the cell chain and the result register.
// Throughput: one sample per cycle while out_ch.ready is high and each sample
//   closes at most one window; a sample that closes more holds the pipeline
//   until the single result register has sent one word for each. At the last
//   row and column of a plane up to 64 windows close with padding and overlap.
// Reset: geometry registers take reset values, trackers position zero; the
//   line store needs no clearing, only rows of the current plane are read.
// Stall: when out_ch.ready is low the result register holds and the sample
//   pipeline (column-maxima stage, cell-chain stage, sequencer) fills up before
//   in_ch.ready drops.
`timescale 1ns / 1ps

module max_pool_2d_unit #(
  parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL  = mp2d_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mp2d_in_if.sink                          in_ch,
  mp2d_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mp2d_pkg::*;

  localparam int POS_W  = $clog2(MAX_WIDTH);
  localparam int IDX_W  = POS_W + 1;
  localparam int SW     = $clog2(MAX_WIDTH + 32) + 1;
  localparam int CMP_W  = (SIZE_REG_W > POS_W + 1) ? SIZE_REG_W : POS_W + 1;

  typedef logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] col_vec_t;
  typedef logic [MAX_KERNEL-2:0][SAMPLE_BITS-1:0] line_t;

  // ---------------- configuration registers ----------------
  logic [KER_REG_W-1:0]  kr_r, kr_nxt, kc_r, kc_nxt;
  logic [STR_REG_W-1:0]  sr_r, sr_nxt, sc_r, sc_nxt;
  logic [PAD_REG_W-1:0]  pr_r, pr_nxt, pc_r, pc_nxt;
  logic [SIZE_REG_W-1:0] nr_r, nr_nxt, nc_r, nc_nxt;
  logic                  restart_r;

  // Decode a register write
  always_comb begin
    kr_nxt = kr_r;
    kc_nxt = kc_r;
    sr_nxt = sr_r;
    sc_nxt = sc_r;
    pr_nxt = pr_r;
    pc_nxt = pc_r;
    nr_nxt = nr_r;
    nc_nxt = nc_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KERNEL_ROWS: kr_nxt = cfg_wdata[KER_REG_W-1:0];
        REG_KERNEL_COLS: kc_nxt = cfg_wdata[KER_REG_W-1:0];
        REG_STRIDE_ROWS: sr_nxt = cfg_wdata[STR_REG_W-1:0];
        REG_STRIDE_COLS: sc_nxt = cfg_wdata[STR_REG_W-1:0];
        REG_PAD_ROWS:    pr_nxt = cfg_wdata[PAD_REG_W-1:0];
        REG_PAD_COLS:    pc_nxt = cfg_wdata[PAD_REG_W-1:0];
        REG_IN_ROWS:     nr_nxt = cfg_wdata[SIZE_REG_W-1:0];
        REG_IN_COLS:     nc_nxt = cfg_wdata[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kr_r      <= KER_RST;
      kc_r      <= KER_RST;
      sr_r      <= STR_RST;
      sc_r      <= STR_RST;
      pr_r      <= PAD_RST;
      pc_r      <= PAD_RST;
      nr_r      <= SIZE_RST;
      nc_r      <= SIZE_RST;
      restart_r <= 1'b1;
    end else begin
      kr_r      <= kr_nxt;
      kc_r      <= kc_nxt;
      sr_r      <= sr_nxt;
      sc_r      <= sc_nxt;
      pr_r      <= pr_nxt;
      pc_r      <= pc_nxt;
      nr_r      <= nr_nxt;
      nc_r      <= nc_nxt;
      restart_r <= cfg_we;
    end
  end

  // ---------------- effective geometry ----------------
  axis_cfg_t            row_cfg, col_cfg;
  logic [POS_W-1:0]     row_last, col_last;
  logic signed [SW-1:0] row_lim, col_lim;

  function automatic axis_cfg_t fit_axis(input logic [KER_REG_W-1:0] k,
                                         input logic [STR_REG_W-1:0] s,
                                         input logic [PAD_REG_W-1:0] p);
    axis_cfg_t a;
    if (k == '0) begin
      a.kernel = KER_EFF_W'(1);
    end else if (KER_EFF_W'(k) > KER_EFF_W'(MAX_KERNEL)) begin
      a.kernel = KER_EFF_W'(MAX_KERNEL);
    end else begin
      a.kernel = KER_EFF_W'(k);
    end
    a.stride = (s == '0) ? STR_REG_W'(1) : s;
    if (KER_EFF_W'(p) > a.kernel - KER_EFF_W'(1)) begin
      a.pad = PAD_REG_W'(a.kernel - KER_EFF_W'(1));
    end else begin
      a.pad = p;
    end
    return a;
  endfunction

  function automatic logic [POS_W-1:0] fit_last(input logic [SIZE_REG_W-1:0] n);
    logic [POS_W-1:0] l;
    if (n == '0) begin
      l = '0;
    end else if (CMP_W'(n) > CMP_W'(MAX_WIDTH)) begin
      l = POS_W'(MAX_WIDTH - 1);
    end else begin
      l = POS_W'(n - SIZE_REG_W'(1));
    end
    return l;
  endfunction

  // Last window origin allowed on each axis: in + pad - kernel
  always_comb begin
    row_cfg  = fit_axis(kr_r, sr_r, pr_r);
    col_cfg  = fit_axis(kc_r, sc_r, pc_r);
    row_last = fit_last(nr_r);
    col_last = fit_last(nc_r);
    row_lim  = SW'(row_last) + SW'(1) + SW'(row_cfg.pad) - SW'(row_cfg.kernel);
    col_lim  = SW'(col_last) + SW'(1) + SW'(col_cfg.pad) - SW'(col_cfg.kernel);
  end

  // ---------------- position trackers ----------------
  logic                 acc;
  logic [POS_W-1:0]     rpos, cpos;
  logic                 rhit, chit, rlast, clast;
  logic [IDX_W-1:0]     ridx, cidx;
  logic signed [SW-1:0] rstart, cstart;

  assign acc = in_ch.valid && in_ch.ready;

  mp2d_axis_trk #(.MAX_WIDTH(MAX_WIDTH)) u_row_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .init    (restart_r),
    .step    (acc && clast),
    .acfg    (row_cfg),
    .n_last  (row_last),
    .lim     (row_lim),
    .pos     (rpos),
    .hit     (rhit),
    .at_last (rlast),
    .idx     (ridx),
    .start   (rstart)
  );

  mp2d_axis_trk #(.MAX_WIDTH(MAX_WIDTH)) u_col_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .init    (restart_r),
    .step    (acc),
    .acfg    (col_cfg),
    .n_last  (col_last),
    .lim     (col_lim),
    .pos     (cpos),
    .hit     (chit),
    .at_last (clast),
    .idx     (cidx),
    .start   (cstart)
  );

  // ---------------- pipeline handshake ----------------
  logic s1_v_r, s2_v_r;
  logic s1_adv, s2_adv, s2_free, s1_free, e_take;

  assign s2_adv      = s2_v_r && e_take;
  assign s2_free     = !s2_v_r || s2_adv;
  assign s1_adv      = s1_v_r && s2_free;
  assign s1_free     = !s1_v_r || s1_adv;
  assign in_ch.ready = s1_free && !restart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= acc;
      end
      if (s2_free) begin
        s2_v_r <= s1_adv;
      end
    end
  end

  // ---------------- stage 1: line store read, column maxima ----------------
  line_t                  line_mem [MAX_WIDTH];
  line_t                  rd_r, fwd_vec_r, prev_vec;
  logic                   fwd_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [POS_W-1:0]       s1_r_r, s1_c_r;
  logic                   s1_rhit_r, s1_rmulti_r, s1_chit_r, s1_cmulti_r;
  logic [IDX_W-1:0]       s1_ridx_r, s1_cidx_r;
  logic signed [SW-1:0]   s1_rstart_r, s1_cstart_r;
  col_vec_t               v_nxt;

  // Read the column's maxima of the rows above; forward when the previous
  // sample hit the same column and is being written right now
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r        <= line_mem[cpos];
      fwd_r       <= s1_v_r && (s1_c_r == cpos);
      fwd_vec_r   <= v_nxt[MAX_KERNEL-2:0];
      s1_sample_r <= in_ch.sample;
      s1_r_r      <= rpos;
      s1_c_r      <= cpos;
      s1_rhit_r   <= rhit;
      s1_rmulti_r <= rlast;
      s1_ridx_r   <= ridx;
      s1_rstart_r <= rstart;
      s1_chit_r   <= chit;
      s1_cmulti_r <= clast;
      s1_cidx_r   <= cidx;
      s1_cstart_r <= cstart;
    end
  end

  // Extend each column maximum down by the new sample
  always_comb begin
    prev_vec = fwd_r ? fwd_vec_r : rd_r;
    v_nxt[0] = s1_sample_r;
    for (int d = 1; d < MAX_KERNEL; d++) begin
      if ($signed(prev_vec[d-1]) > $signed(s1_sample_r)) begin
        v_nxt[d] = prev_vec[d-1];
      end else begin
        v_nxt[d] = s1_sample_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_c_r] <= v_nxt[MAX_KERNEL-2:0];
    end
  end

  // ---------------- stage 2: column vector into the cell chain ----------------
  col_vec_t             s2_vec_r;
  logic [POS_W-1:0]     s2_r_r, s2_c_r;
  logic                 s2_rhit_r, s2_rmulti_r, s2_chit_r, s2_cmulti_r;
  logic [IDX_W-1:0]     s2_ridx_r, s2_cidx_r;
  logic signed [SW-1:0] s2_rstart_r, s2_cstart_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_vec_r    <= v_nxt;
      s2_r_r      <= s1_r_r;
      s2_c_r      <= s1_c_r;
      s2_rhit_r   <= s1_rhit_r;
      s2_rmulti_r <= s1_rmulti_r;
      s2_ridx_r   <= s1_ridx_r;
      s2_rstart_r <= s1_rstart_r;
      s2_chit_r   <= s1_chit_r;
      s2_cmulti_r <= s1_cmulti_r;
      s2_cidx_r   <= s1_cidx_r;
      s2_cstart_r <= s1_cstart_r;
    end
  end

  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] grid;

  // Cell e holds maxima over the last e+1 columns
  for (genvar e = 0; e < MAX_KERNEL; e++) begin : g_cell
    if (e == 0) begin : g_head
      mp2d_cell #(.MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk     (clk),
        .en      (s2_adv),
        .first   (1'b1),
        .col_max (s2_vec_r),
        .left    (grid[0]),
        .win_max (grid[0])
      );
    end else begin : g_body
      mp2d_cell #(.MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk     (clk),
        .en      (s2_adv),
        .first   (1'b0),
        .col_max (s2_vec_r),
        .left    (grid[e-1]),
        .win_max (grid[e])
      );
    end
  end

  // ---------------- result sequencer ----------------
  mp2d_emitter #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s2_adv),
    .take      (e_take),
    .row_pos   (s2_r_r),
    .col_pos   (s2_c_r),
    .row_hit   (s2_rhit_r),
    .row_multi (s2_rmulti_r),
    .row_idx   (s2_ridx_r),
    .row_start (s2_rstart_r),
    .col_hit   (s2_chit_r),
    .col_multi (s2_cmulti_r),
    .col_idx   (s2_cidx_r),
    .col_start (s2_cstart_r),
    .row_cfg   (row_cfg),
    .col_cfg   (col_cfg),
    .row_lim   (row_lim),
    .col_lim   (col_lim),
    .grid      (grid),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/mp2d_axis_trk.sv
// Position tracker of one axis: current position and the next window to close.
// Depends on mp2d_pkg.
`timescale 1ns / 1ps

module mp2d_axis_trk #(
  parameter int MAX_WIDTH = mp2d_pkg::DEF_MAX_WIDTH,
  localparam int POS_W = $clog2(MAX_WIDTH),
  localparam int IDX_W = POS_W + 1,
  localparam int SW    = $clog2(MAX_WIDTH + 32) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                init,
  input  logic                step,
  input  mp2d_pkg::axis_cfg_t acfg,
  input  logic [POS_W-1:0]    n_last,
  input  logic signed [SW-1:0] lim,
  output logic [POS_W-1:0]    pos,
  output logic                hit,
  output logic                at_last,
  output logic [IDX_W-1:0]    idx,
  output logic signed [SW-1:0] start
);
  import mp2d_pkg::*;

  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic signed [SW-1:0] start_r, start_nxt;
  logic signed [SW-1:0] end_r, end_nxt;
  logic signed [SW-1:0] pos_s;
  logic signed [SW-1:0] init_start, init_end;
  logic                 at_end;

  assign pos_s      = SW'(pos_r);
  assign init_start = SW'(0) - SW'(acfg.pad);
  assign init_end   = SW'(acfg.kernel) - SW'(1) - SW'(acfg.pad);
  assign at_end     = (pos_s == end_r);
  assign at_last    = (pos_r == n_last);

  // A window closes here if its end is reached or the axis ends; it must exist
  assign hit   = (at_end || at_last) && (start_r <= lim);
  assign pos   = pos_r;
  assign idx   = idx_r;
  assign start = start_r;

  // Advance position; step to the next window when this one closes
  always_comb begin
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    if (init || (step && at_last)) begin
      pos_nxt   = '0;
      idx_nxt   = '0;
      start_nxt = init_start;
      end_nxt   = init_end;
    end else if (step) begin
      pos_nxt = pos_r + POS_W'(1);
      if (at_end) begin
        idx_nxt   = idx_r + IDX_W'(1);
        start_nxt = start_r + SW'(acfg.stride);
        end_nxt   = end_r + SW'(acfg.stride);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      idx_r   <= '0;
      start_r <= '0;
      end_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

FILE: rtl/mp2d_cell.sv
// One cell of the horizontal chain: running maxima over a span of columns,
// one value for each window height. Depends on mp2d_pkg.
`timescale 1ns / 1ps

module mp2d_cell #(
  parameter int MAX_KERNEL  = mp2d_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic                                    first,
  input  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]  col_max,
  input  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]  left,
  output logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0]  win_max
);
  import mp2d_pkg::*;

  logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] win_r, win_nxt;

  // Merge the new column into the span handed over by the left neighbor
  always_comb begin
    for (int d = 0; d < MAX_KERNEL; d++) begin
      if (first || ($signed(col_max[d]) > $signed(left[d]))) begin
        win_nxt[d] = col_max[d];
      end else begin
        win_nxt[d] = left[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win_r <= win_nxt;
    end
  end

  assign win_max = win_r;

endmodule

FILE: rtl/mp2d_emitter.sv
// Result sequencer: walks the windows that close on one sample and drives the
// registered result channel. Depends on mp2d_pkg and mp2d_if.
`timescale 1ns / 1ps

module mp2d_emitter #(
  parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL  = mp2d_pkg::DEF_MAX_KERNEL,
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS,
  localparam int POS_W = $clog2(MAX_WIDTH),
  localparam int IDX_W = POS_W + 1,
  localparam int SW    = $clog2(MAX_WIDTH + 32) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  output logic                 take,
  input  logic [POS_W-1:0]     row_pos,
  input  logic [POS_W-1:0]     col_pos,
  input  logic                 row_hit,
  input  logic                 row_multi,
  input  logic [IDX_W-1:0]     row_idx,
  input  logic signed [SW-1:0] row_start,
  input  logic                 col_hit,
  input  logic                 col_multi,
  input  logic [IDX_W-1:0]     col_idx,
  input  logic signed [SW-1:0] col_start,
  input  mp2d_pkg::axis_cfg_t  row_cfg,
  input  mp2d_pkg::axis_cfg_t  col_cfg,
  input  logic signed [SW-1:0] row_lim,
  input  logic signed [SW-1:0] col_lim,
  input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_BITS-1:0] grid,
  mp2d_out_if.source           out_ch
);
  import mp2d_pkg::*;

  localparam int KW = $clog2(MAX_KERNEL);

  logic                   busy_r, busy_nxt;
  logic [POS_W-1:0]       r_r, r_nxt, c_r, c_nxt;
  logic                   rmulti_r, rmulti_nxt, cmulti_r, cmulti_nxt;
  logic [IDX_W-1:0]       i_r, i_nxt, j_r, j_nxt, j0_r, j0_nxt;
  logic signed [SW-1:0]   rs_r, rs_nxt, cs_r, cs_nxt, cs0_r, cs0_nxt;
  logic signed [SW-1:0]   rs_step, cs_step, rs_clip, cs_clip, d_full, e_full;
  logic [KW-1:0]          d_sel, e_sel;
  logic                   more_r, more_c, last_one, emit;

  logic                   ov_r, ov_nxt;
  logic [SAMPLE_BITS-1:0] pooled_r, pooled_nxt;
  logic [POS_W-1:0]       orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic                   eop_r, eop_nxt, last_r, last_nxt;

  // Window offsets into the cell grid and what follows this window
  always_comb begin
    rs_step  = rs_r + SW'(row_cfg.stride);
    cs_step  = cs_r + SW'(col_cfg.stride);
    rs_clip  = (rs_r < 0) ? SW'(0) : rs_r;
    cs_clip  = (cs_r < 0) ? SW'(0) : cs_r;
    d_full   = SW'(r_r) - rs_clip;
    e_full   = SW'(c_r) - cs_clip;
    d_sel    = d_full[KW-1:0];
    e_sel    = e_full[KW-1:0];
    more_r   = rmulti_r && (rs_step <= row_lim);
    more_c   = cmulti_r && (cs_step <= col_lim);
    last_one = !more_c && !more_r;
    emit     = busy_r && (!ov_r || out_ch.ready);
    take     = !busy_r || (emit && last_one);
  end

  // Load a new sample's window lists or walk the columns of a row, then the next row
  always_comb begin
    busy_nxt   = busy_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    rmulti_nxt = rmulti_r;
    cmulti_nxt = cmulti_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    j0_nxt     = j0_r;
    rs_nxt     = rs_r;
    cs_nxt     = cs_r;
    cs0_nxt    = cs0_r;
    if (load) begin
      busy_nxt   = row_hit && col_hit;
      r_nxt      = row_pos;
      c_nxt      = col_pos;
      rmulti_nxt = row_multi;
      cmulti_nxt = col_multi;
      i_nxt      = row_idx;
      rs_nxt     = row_start;
      j_nxt      = col_idx;
      j0_nxt     = col_idx;
      cs_nxt     = col_start;
      cs0_nxt    = col_start;
    end else if (emit) begin
      if (more_c) begin
        j_nxt  = j_r + IDX_W'(1);
        cs_nxt = cs_step;
      end else if (more_r) begin
        i_nxt  = i_r + IDX_W'(1);
        rs_nxt = rs_step;
        j_nxt  = j0_r;
        cs_nxt = cs0_r;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Output word register: fill on emit, drop when taken
  always_comb begin
    ov_nxt     = ov_r;
    pooled_nxt = pooled_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    eop_nxt    = eop_r;
    last_nxt   = last_r;
    if (emit) begin
      ov_nxt     = 1'b1;
      pooled_nxt = grid[e_sel][d_sel];
      orow_nxt   = i_r[POS_W-1:0];
      ocol_nxt   = j_r[POS_W-1:0];
      eop_nxt    = (rs_step > row_lim) && (cs_step > col_lim);
      last_nxt   = last_one;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    rmulti_r <= rmulti_nxt;
    cmulti_r <= cmulti_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    j0_r     <= j0_nxt;
    rs_r     <= rs_nxt;
    cs_r     <= cs_nxt;
    cs0_r    <= cs0_nxt;
    pooled_r <= pooled_nxt;
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
    eop_r    <= eop_nxt;
    last_r   <= last_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.pooled       = pooled_r;
  assign out_ch.out_row      = orow_r;
  assign out_ch.out_col      = ocol_r;
  assign out_ch.end_of_plane = eop_r;
  assign out_ch.last         = last_r;

endmodule

FILE: tb/max_pool_2d_unit_test.sv
// Self-checking testbench of max_pool_2d_unit: directed planes, then random geometries.
// Depends on mp2d_pkg, mp2d_if and the max_pool_2d_unit RTL; every word is checked
// against a window-maximum predictor that runs inside this module.
`timescale 1ns / 1ps

module max_pool_2d_unit_test;
  import mp2d_pkg::*;

  localparam int LINE_W    = 1024;
  localparam int LINES     = 8;
  localparam int STALL_MAX = 20000;

  typedef struct {
    logic [15:0] pooled;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        eop;
    logic        last;
  } pool_word_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    idx;
    logic [10:0] value;
    logic [15:0] sample;
    bit          pinned;
    pool_word_t  want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mp2d_in_if  in_ch ();
  mp2d_out_if out_ch ();

  max_pool_2d_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: geometry registers, line store, raster position
  logic [10:0] geo [8];
  int          line_buf [LINES][LINE_W];
  int          row_pos;
  int          col_pos;

  pool_word_t  pooled_q [$];
  stim_row_t   plan [$];
  int          errors;
  int          stall_cnt;
  int          src_idle;
  int          sink_idle;
  bit          pin_now;
  pool_word_t  pin_word;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int out_span(int n_in, int k, int s, int p);
    int num;
    num = n_in + 2 * p - k;
    return num < 0 ? 0 : num / s + 1;
  endfunction

  // List the windows of one axis whose last real position is pos
  function automatic int closing(int pos, int n_in, int k, int s, int p, int n_out,
                                 ref int lst[LINES]);
    int cnt;
    int e;
    cnt = 0;
    for (int i = 0; i < n_out && cnt < LINES; i++) begin
      e = i * s - p + k - 1;
      if (e > n_in - 1) e = n_in - 1;
      if (e == pos) begin
        lst[cnt] = i;
        cnt++;
      end
    end
    return cnt;
  endfunction

  function automatic logic [10:0] reg_mask(cfg_reg_t idx, logic [10:0] v);
    case (idx)
      REG_KERNEL_ROWS, REG_KERNEL_COLS, REG_STRIDE_ROWS, REG_STRIDE_COLS: begin
        return v & 11'h00f;
      end
      REG_PAD_ROWS, REG_PAD_COLS: begin
        return v & 11'h007;
      end
      default: begin
        return v;
      end
    endcase
  endfunction

  function automatic bit same_word(pool_word_t a, pool_word_t b);
    return a.pooled == b.pooled && a.row == b.row && a.col == b.col &&
           a.eop == b.eop && a.last == b.last;
  endfunction

  // Store one accepted sample and queue every window it closes
  function automatic void pool_sample(logic [15:0] s);
    int kr, kc, sr, sc, pr, pc, nr, nc, orows, ocols, r, c, nrl, ncl, n;
    int r0, c0, r1, c1, best;
    int rl[LINES];
    int cl[LINES];
    pool_word_t words [$];
    pool_word_t w;
    kr = clip(geo[REG_KERNEL_ROWS], 1, LINES);
    kc = clip(geo[REG_KERNEL_COLS], 1, LINES);
    sr = clip(geo[REG_STRIDE_ROWS], 1, 15);
    sc = clip(geo[REG_STRIDE_COLS], 1, 15);
    pr = clip(geo[REG_PAD_ROWS], 0, kr - 1);
    pc = clip(geo[REG_PAD_COLS], 0, kc - 1);
    nr = clip(geo[REG_IN_ROWS], 1, LINE_W);
    nc = clip(geo[REG_IN_COLS], 1, LINE_W);
    orows = out_span(nr, kr, sr, pr);
    ocols = out_span(nc, kc, sc, pc);
    r = row_pos >= nr ? 0 : row_pos;
    c = col_pos >= nc ? 0 : col_pos;
    line_buf[r % LINES][c] = int'($signed(s));
    nrl = closing(r, nr, kr, sr, pr, orows, rl);
    ncl = closing(c, nc, kc, sc, pc, ocols, cl);
    n = 0;
    for (int a = 0; a < nrl; a++) begin
      for (int b = 0; b < ncl && n < 64; b++) begin
        r0 = rl[a] * sr - pr;
        c0 = cl[b] * sc - pc;
        r1 = clip(r0 + kr - 1, 0, nr - 1);
        c1 = clip(c0 + kc - 1, 0, nc - 1);
        r0 = r0 < 0 ? 0 : r0;
        c0 = c0 < 0 ? 0 : c0;
        best = line_buf[r0 % LINES][c0];
        for (int y = r0; y <= r1; y++)
          for (int x = c0; x <= c1; x++)
            if (line_buf[y % LINES][x] > best) best = line_buf[y % LINES][x];
        w.pooled = best[15:0];
        w.row    = rl[a][9:0];
        w.col    = cl[b][9:0];
        w.eop    = (rl[a] == orows - 1) && (cl[b] == ocols - 1);
        w.last   = 1'b0;
        words.push_back(w);
        n++;
      end
    end
    if (n > 0) words[n - 1].last = 1'b1;
    if (pin_now && (n == 0 || !same_word(words[n - 1], pin_word))) begin
      errors++;
      if (errors <= 10)
        $display("directed row: predicted %p (count %0d), typed %p", words, n, pin_word);
    end
    foreach (words[i]) pooled_q.push_back(words[i]);
    c++;
    if (c >= nc) begin
      c = 0;
      r++;
      if (r >= nr) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  // Predict on accepted samples, check accepted words, watch for stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        pool_sample(in_ch.sample);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pooled_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: pooled %h row %0d col %0d", out_ch.pooled,
                     out_ch.out_row, out_ch.out_col);
        end else begin
          pool_word_t w;
          w = pooled_q.pop_front();
          if (w.pooled !== out_ch.pooled || w.row !== out_ch.out_row ||
              w.col !== out_ch.out_col || w.eop !== out_ch.end_of_plane ||
              w.last !== out_ch.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected pooled %h row %0d col %0d eop %b last %b,",
                        " got %h %0d %0d %b %b"},
                       w.pooled, w.row, w.col, w.eop, w.last, out_ch.pooled,
                       out_ch.out_row, out_ch.out_col, out_ch.end_of_plane, out_ch.last);
          end
        end
      end
      if (stall_cnt >= STALL_MAX) begin
        $display("max_pool_2d_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle);
  end

  // Wait for every pending word, then let the pipeline drain
  task automatic settle();
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [10:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    geo[idx] = reg_mask(idx, v);
    row_pos  = 0;
    col_pos  = 0;
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one sample word and hold it until accepted
  task automatic send_sample(logic [15:0] s, bit pinned, pool_word_t want);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pin_now  = pinned;
    pin_word = want;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic add_cfg(cfg_reg_t idx, logic [10:0] v);
    stim_row_t t;
    t = '{ROW_CFG, idx, v, 16'h0, 1'b0, '{16'h0, 10'd0, 10'd0, 1'b0, 1'b0}};
    plan.push_back(t);
  endtask

  task automatic add_smp(logic [15:0] s, bit pinned, logic [15:0] p);
    stim_row_t t;
    t = '{ROW_SAMPLE, REG_KERNEL_ROWS, 11'd0, s, pinned, '{p, 10'd0, 10'd0, 1'b1, 1'b1}};
    plan.push_back(t);
  endtask

  initial begin
    stim_row_t   t;
    bit          in_cfg;
    logic [10:0] rv [8];
    int          planes;
    int          items;
    pool_word_t  none;
    none = '{16'h0, 10'd0, 10'd0, 1'b0, 1'b0};
    errors    = 0;
    stall_cnt = 0;
    src_idle  = 37;
    sink_idle = 45;
    pin_now   = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    geo = '{KER_RST, KER_RST, STR_RST, STR_RST, PAD_RST, PAD_RST, SIZE_RST, SIZE_RST};
    row_pos = 0;
    col_pos = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2x2 plane with reset geometry, both extremes win once
    add_cfg(REG_IN_ROWS, 11'd2);
    add_cfg(REG_IN_COLS, 11'd2);
    add_smp(16'h7fff, 0, 16'h0);
    add_smp(16'h8000, 0, 16'h0);
    add_smp(16'h0001, 0, 16'h0);
    add_smp(16'hffff, 1, 16'h7fff);
    for (int i = 0; i < 3; i++) add_smp(16'h8000, 0, 16'h0);
    add_smp(16'h8000, 1, 16'h8000);
    // Zero kernel, stride and size act as one; pad clamps to kernel - 1
    add_cfg(REG_KERNEL_ROWS, 11'd0);
    add_cfg(REG_KERNEL_COLS, 11'd0);
    add_cfg(REG_STRIDE_ROWS, 11'd0);
    add_cfg(REG_STRIDE_COLS, 11'd0);
    add_cfg(REG_PAD_ROWS, 11'd7);
    add_cfg(REG_PAD_COLS, 11'd7);
    add_cfg(REG_IN_ROWS, 11'd0);
    add_cfg(REG_IN_COLS, 11'd0);
    add_smp(16'h1234, 1, 16'h1234);
    // Oversized kernel, full stride and pad on a 3x3 plane
    add_cfg(REG_KERNEL_ROWS, 11'd15);
    add_cfg(REG_KERNEL_COLS, 11'd15);
    add_cfg(REG_STRIDE_ROWS, 11'd15);
    add_cfg(REG_STRIDE_COLS, 11'd15);
    add_cfg(REG_IN_ROWS, 11'd3);
    add_cfg(REG_IN_COLS, 11'd3);
    for (int i = 0; i < 9; i++) add_smp(16'(i * 16'h1111), 0, 16'h0);
    // Kernel larger than the unpadded plane: no windows at all
    add_cfg(REG_PAD_ROWS, 11'd0);
    add_cfg(REG_PAD_COLS, 11'd0);
    add_cfg(REG_IN_ROWS, 11'd2);
    add_cfg(REG_IN_COLS, 11'd2);
    for (int i = 0; i < 4; i++) add_smp(16'h7fff, 0, 16'h0);

    in_cfg = 1'b0;
    settle();
    foreach (plan[i]) begin
      t = plan[i];
      if (t.kind == ROW_CFG) begin
        if (!in_cfg) begin
          @(negedge clk);
          in_ch.valid <= 1'b0;
          settle();
          in_cfg = 1'b1;
        end
        write_reg(t.idx, t.value);
      end else begin
        if (in_cfg) begin
          close_writes();
          in_cfg = 1'b0;
        end
        send_sample(t.sample, t.pinned, t.want);
      end
    end

    // Random geometries, whole planes mostly, some cut short
    for (int mode = 0; mode < 3; mode++) begin
      src_idle  = mode == 0 ? 37 : (mode == 1 ? 45 : 0);
      sink_idle = mode == 0 ? 45 : (mode == 1 ? 37 : 0);
      items = 0;
      while (items < 100) begin
        rv[REG_KERNEL_ROWS] = $urandom_range(7) == 0 ?
                              11'($urandom_range(15)) : 11'($urandom_range(1, 4));
        rv[REG_KERNEL_COLS] = $urandom_range(7) == 0 ?
                              11'($urandom_range(15)) : 11'($urandom_range(1, 4));
        rv[REG_STRIDE_ROWS] = $urandom_range(7) == 0 ?
                              11'($urandom_range(15)) : 11'($urandom_range(1, 3));
        rv[REG_STRIDE_COLS] = $urandom_range(7) == 0 ?
                              11'($urandom_range(15)) : 11'($urandom_range(1, 3));
        rv[REG_PAD_ROWS]    = 11'($urandom_range(7));
        rv[REG_PAD_COLS]    = 11'($urandom_range(7));
        rv[REG_IN_ROWS]     = 11'($urandom_range(1, 9));
        rv[REG_IN_COLS]     = $urandom_range(15) == 0 ?
                              11'h7ff : 11'($urandom_range(1, 9));
        planes = $urandom_range(1, 2);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        settle();
        for (int r = 0; r < 8; r++) write_reg(cfg_reg_t'(r), rv[r]);
        close_writes();
        if (rv[REG_IN_COLS] == 11'h7ff) begin
          // Wide plane: one partial row only
          repeat (40) begin
            send_sample(16'($urandom), 0, none);
            items++;
          end
        end else begin
          for (int p = 0; p < planes; p++) begin
            int cnt;
            cnt = rv[REG_IN_ROWS] * rv[REG_IN_COLS];
            if ($urandom_range(7) == 0) cnt = $urandom_range(1, cnt);
            for (int k = 0; k < cnt; k++) begin
              send_sample(16'($urandom), 0, none);
              items++;
            end
          end
        end
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("max_pool_2d_unit_test OK");
    end else begin
      $display("max_pool_2d_unit_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mp2d_pkg.sv
rtl/mp2d_if.sv
rtl/mp2d_axis_trk.sv
rtl/mp2d_cell.sv
rtl/mp2d_emitter.sv
rtl/max_pool_2d_unit.sv
tb/max_pool_2d_unit_test.sv
